// ===== hdl/md5ds_pkg.sv =====
// Package for the streaming MD5 digest block: sequencer states, initial
// chaining words and the per-round tables (constants, rotations, word order).
// No dependencies.
`default_nettype none

package md5ds_pkg;

    // Initial chaining words
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;
    // First byte position of the length field; the marker must lie before it
    localparam logic [5:0] LEN_POS = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RND0,
        ST_RND1,
        ST_FIN,
        ST_OUT
    } t_state;

    // Additive round constant
    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left rotation amount, by round group and position within the group of four
    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by round i
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] j;
        logic [3:0] g;
        j = i[3:0];
        case (i[5:4])
            2'd0:    g = j;
            2'd1:    g = 4'(j * 4'd5 + 4'd1);
            2'd2:    g = 4'(j * 4'd3 + 4'd5);
            2'd3:    g = 4'(j * 4'd7);
            default: g = j;
        endcase
        return g;
    endfunction

    // Round boolean function
    function automatic logic [31:0] md5_f(input logic [1:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (rnd)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = 32'h0;
        endcase
        return f;
    endfunction

    // 32-bit left rotate by a variable amount
    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/md5_digest_stream.sv =====
// Streaming MD5 digest: byte input stream, four-word digest output stream.
// Completing a 64-byte block runs a compression (one shared round unit, each of
// the 64 rounds in ST_RND0 then ST_RND1, plus the final add). A last transaction
// adds padding to the end of each padded block, one or two compressions, then
// four output transactions. Not ready meanwhile.
// Synchronous active-low reset loads the initial chaining words, clears counters.
`default_nettype none

module md5_digest_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // last_byte
    // Digest output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import md5ds_pkg::*;

    // Control registers
    t_state      r_state, n_state;
    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic [63:0] r_bit_count, n_bit_count;
    logic [5:0]  r_fill, n_fill;
    logic [5:0]  r_pad_pos, n_pad_pos;
    logic        r_mark, n_mark;
    logic        r_final_blk, n_final_blk;
    logic        r_in_pad, n_in_pad;
    logic        r_msg_last, n_msg_last;
    logic [5:0]  r_round, n_round;
    logic [1:0]  r_out_idx, n_out_idx;

    // Round datapath registers
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_rdata;

    // Block buffer: sixteen little-endian words, byte-wide writes
    logic [31:0] r_mem [16];
    logic        mem_we;
    logic [5:0]  mem_pos;
    logic [7:0]  mem_byte;

    logic        in_acc;
    logic [5:0]  fill_next;
    logic [31:0] rot_val;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign fill_next = r_fill + 6'(s_axis_tuser);
    assign rot_val   = rotl32(r_sum + r_rdata, md5_s(r_round));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_chain[r_out_idx];
    assign m_axis_tuser  = r_out_idx;
    assign m_axis_tlast  = (r_out_idx == 2'd3);

    // Sequencer: next state, next register values, buffer write port
    always_comb begin
        n_state     = r_state;
        n_chain     = r_chain;
        n_bit_count = r_bit_count;
        n_fill      = r_fill;
        n_pad_pos   = r_pad_pos;
        n_mark      = r_mark;
        n_final_blk = r_final_blk;
        n_in_pad    = r_in_pad;
        n_msg_last  = r_msg_last;
        n_round     = r_round;
        n_out_idx   = r_out_idx;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_sum       = r_sum;
        mem_we      = 1'b0;
        mem_pos     = r_pad_pos;
        mem_byte    = 8'h00;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser) begin
                        mem_we      = 1'b1;
                        mem_pos     = r_fill;
                        mem_byte    = s_axis_tdata;
                        n_fill      = fill_next;
                        n_bit_count = r_bit_count + 64'd8;
                    end
                    if (s_axis_tuser && r_fill == 6'd63) begin
                        // block full: compress, padding follows if last
                        n_msg_last = s_axis_tlast;
                        n_in_pad   = 1'b0;
                        n_a        = r_chain[0];
                        n_b        = r_chain[1];
                        n_c        = r_chain[2];
                        n_d        = r_chain[3];
                        n_round    = 6'd0;
                        n_state    = ST_RND0;
                    end else if (s_axis_tlast) begin
                        n_pad_pos   = fill_next;
                        n_mark      = 1'b1;
                        n_final_blk = (fill_next < LEN_POS);
                        n_in_pad    = 1'b1;
                        n_state     = ST_PAD;
                    end
                end
            end

            ST_PAD: begin
                // one padding byte a cycle: marker, zeros, then the length
                mem_we  = 1'b1;
                mem_pos = r_pad_pos;
                if (r_mark) begin
                    mem_byte = PAD_MARK;
                end else if (r_final_blk && r_pad_pos >= LEN_POS) begin
                    mem_byte = r_bit_count[{r_pad_pos[2:0], 3'b000} +: 8];
                end else begin
                    mem_byte = 8'h00;
                end
                n_mark    = 1'b0;
                n_pad_pos = r_pad_pos + 6'd1;
                if (r_pad_pos == 6'd63) begin
                    n_a     = r_chain[0];
                    n_b     = r_chain[1];
                    n_c     = r_chain[2];
                    n_d     = r_chain[3];
                    n_round = 6'd0;
                    n_state = ST_RND0;
                end
            end

            ST_RND0: begin
                // first half of a round; message word is fetched meanwhile
                n_sum   = r_a + md5_f(r_round[5:4], r_b, r_c, r_d) + md5_k(r_round);
                n_state = ST_RND1;
            end

            ST_RND1: begin
                n_b     = r_b + rot_val;
                n_a     = r_d;
                n_d     = r_c;
                n_c     = r_b;
                n_round = r_round + 6'd1;
                n_state = (r_round == 6'd63) ? ST_FIN : ST_RND0;
            end

            ST_FIN: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                if (r_in_pad) begin
                    if (r_final_blk) begin
                        n_out_idx = 2'd0;
                        n_state   = ST_OUT;
                    end else begin
                        // marker went in the first block; length goes in this one
                        n_pad_pos   = 6'd0;
                        n_mark      = 1'b0;
                        n_final_blk = 1'b1;
                        n_state     = ST_PAD;
                    end
                end else if (r_msg_last) begin
                    n_pad_pos   = 6'd0;
                    n_mark      = 1'b1;
                    n_final_blk = 1'b1;
                    n_in_pad    = 1'b1;
                    n_state     = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end

            ST_OUT: begin
                if (m_axis_tready) begin
                    n_out_idx = r_out_idx + 2'd1;
                    if (r_out_idx == 2'd3) begin
                        // digest delivered: start a new message
                        n_chain[0]  = IV0;
                        n_chain[1]  = IV1;
                        n_chain[2]  = IV2;
                        n_chain[3]  = IV3;
                        n_bit_count = 64'd0;
                        n_fill      = 6'd0;
                        n_state     = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0]  <= IV0;
            r_chain[1]  <= IV1;
            r_chain[2]  <= IV2;
            r_chain[3]  <= IV3;
            r_bit_count <= 64'd0;
            r_fill      <= 6'd0;
            r_pad_pos   <= 6'd0;
            r_mark      <= 1'b0;
            r_final_blk <= 1'b0;
            r_in_pad    <= 1'b0;
            r_msg_last  <= 1'b0;
            r_round     <= 6'd0;
            r_out_idx   <= 2'd0;
        end else begin
            r_chain     <= n_chain;
            r_bit_count <= n_bit_count;
            r_fill      <= n_fill;
            r_pad_pos   <= n_pad_pos;
            r_mark      <= n_mark;
            r_final_blk <= n_final_blk;
            r_in_pad    <= n_in_pad;
            r_msg_last  <= n_msg_last;
            r_round     <= n_round;
            r_out_idx   <= n_out_idx;
        end
    end

    // Round working registers
    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_sum <= n_sum;
    end

    // Block buffer: byte write, registered word read for the round unit
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_pos[5:2]][{mem_pos[1:0], 3'b000} +: 8] <= mem_byte;
        end
        if (r_state == ST_RND0) begin
            r_rdata <= r_mem[md5_g(r_round)];
        end
    end

endmodule

`default_nettype wire

// ===== tb/md5_digest_checker.sv =====
// Checker for the streaming MD5 digest block: watches both stream channels,
// predicts the digest words of every message and compares them in order.
// No dependencies; instantiated beside the block by the testbench top.

module md5_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input channel, observed only
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic        i_s_tuser,    // [0] has_byte
    input  logic        i_s_tlast,    // last_byte
    // Digest output channel, observed only
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,    // [31:0] digest_word
    input  logic [1:0]  i_m_tuser,    // [1:0] word_index
    input  logic        i_m_tlast,    // last_word
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        closing;
    } digest_word_t;

    // Per-round additive constants
    logic [31:0] sine_k [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotation per round group (rows) and position in the group of four
    int unsigned shift_amt [16] = '{
        7, 12, 17, 22,  5, 9, 14, 20,  4, 11, 16, 23,  6, 10, 15, 21
    };

    // Predicted state of the hash engine
    logic [31:0]  chain [4];
    logic [7:0]   msg_block [64];
    logic [63:0]  msg_bits;
    int unsigned  fill;
    digest_word_t digest_due [$];

    function automatic void load_initial_chain();
        chain[0] = 32'h67452301;
        chain[1] = 32'hEFCDAB89;
        chain[2] = 32'h98BADCFE;
        chain[3] = 32'h10325476;
        msg_bits = '0;
        fill     = 0;
    endfunction

    // One 64-round compression of msg_block into chain
    function automatic void md5_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t, sum;
        int unsigned i, g, grp, s;
        for (i = 0; i < 16; i++)
            w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (i = 0; i < 64; i++) begin
            grp = i / 16;
            case (grp)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            s   = shift_amt[grp * 4 + (i % 4)];
            sum = a + f + sine_k[i] + w[g];
            t   = d;
            d   = c;
            c   = b;
            b   = b + ((sum << s) | (sum >> (32 - s)));
            a   = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    // Absorb one accepted input transaction; a closing one pads and yields the digest
    function automatic void absorb_item(input logic [7:0] data, input logic has_byte,
                                        input logic closing);
        digest_word_t dw;
        int unsigned k;
        if (has_byte) begin
            msg_block[fill] = data;
            msg_bits += 64'd8;
            fill = (fill + 1) % 64;
            if (fill == 0)
                md5_compress();
        end
        if (closing) begin
            msg_block[fill] = 8'h80;
            fill++;
            // no room left for the length field: extra block
            if (fill > 56) begin
                while (fill < 64) begin
                    msg_block[fill] = 8'h00;
                    fill++;
                end
                md5_compress();
                fill = 0;
            end
            while (fill < 56) begin
                msg_block[fill] = 8'h00;
                fill++;
            end
            for (k = 0; k < 8; k++)
                msg_block[56 + k] = msg_bits[8*k +: 8];
            md5_compress();
            for (k = 0; k < 4; k++) begin
                dw.word    = chain[k];
                dw.index   = 2'(k);
                dw.closing = (k == 3);
                digest_due.push_back(dw);
            end
            load_initial_chain();
        end
    endfunction

    // Track input transactions and check output transactions
    always @(posedge i_clk) begin
        digest_word_t want;
        if (!i_rst_n) begin
            digest_due.delete();
            load_initial_chain();
            o_fail_count    <= 0;
            o_words_checked <= 0;
            o_pending       <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                absorb_item(i_s_tdata, i_s_tuser, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                o_words_checked <= o_words_checked + 1;
                if (digest_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected digest word %h index %0d last %b",
                                 $realtime, i_m_tdata, i_m_tuser, i_m_tlast);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = digest_due.pop_front();
                    if (i_m_tdata !== want.word || i_m_tuser !== want.index ||
                        i_m_tlast !== want.closing) begin
                        if (o_fail_count < 10)
                            $display("%0t: digest word wrong: expected %h/%0d/%b, got %h/%0d/%b",
                                     $realtime, want.word, want.index, want.closing,
                                     i_m_tdata, i_m_tuser, i_m_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= digest_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the MD5 digest stream testbench: clock, reset, byte stimulus and
// output back-pressure. Depends on md5_digest_stream and md5_digest_checker.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] has_byte
    logic        s_axis_tlast = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [1:0]  m_axis_tuser;           // [1:0] word_index
    logic        m_axis_tlast;           // last_word

    int unsigned fail_count, pending, words_checked;
    int unsigned n_bytes = 0, n_ignored = 0, n_messages = 0, n_items = 0;
    int unsigned tx_calm = 0, rx_calm = 0, rx_wait = 0;
    int unsigned msg_len = 0;

    md5_digest_stream dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    md5_digest_checker digest_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_s_tlast       (s_axis_tlast),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .i_m_tlast       (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle cycles before a transaction; now and then a stretch with none
    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Mostly short messages, some around the padding and block boundaries
    function automatic int unsigned pick_length();
        if ($urandom_range(0, 4) < 3)
            return $urandom_range(0, 12);
        case ($urandom_range(0, 7))
            0: return 55;
            1: return 56;
            2: return 57;
            3: return 63;
            4: return 64;
            5: return 119;
            6: return 120;
            default: return 128;
        endcase
    endfunction

    // Present one input transaction and hold it until accepted
    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic closing);
        int unsigned gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has_byte;
        s_axis_tlast  <= closing;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_items++;
        if (has_byte)
            n_bytes++;
        else if (!closing)
            n_ignored++;
        if (closing)
            n_messages++;
    endtask

    // Random message of len bytes, closed on its last byte or by an empty closing item
    task automatic send_message(input int unsigned len);
        logic empty_tail;
        int unsigned k;
        empty_tail = (len == 0) || ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !empty_tail && (k + 1 == len));
        end
        if (empty_tail)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Output back-pressure: random stall after each digest word transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = draw_gap(rx_calm);
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_wait = draw_gap(rx_calm);
            m_axis_tready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= (rx_wait == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored item, then the empty message
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        // "abc"
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // single bytes at both extremes
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        // bytes closed by an empty closing item, then another empty message
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        // ignored item inside a message
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hA5, 1'b1, 1'b1);

        // random messages, trimmed so the run stays near 120 transactions
        while (n_items < 120) begin
            msg_len = pick_length();
            if (msg_len > 120 - n_items)
                msg_len = 120 - n_items;
            send_message(msg_len);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Sent %0d messages: %0d byte transactions, %0d ignored transactions",
                 n_messages, n_bytes, n_ignored);
        $display("Checked %0d digest words, %0d errors", words_checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("md5_digest_stream: match");
        else
            $display("md5_digest_stream: mismatch");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #1000000;
        $display("Timed out with %0d digest words outstanding", pending);
        $display("md5_digest_stream: mismatch");
        $finish;
    end

endmodule

// ===== md5_digest_stream.f =====
hdl/md5ds_pkg.sv
hdl/md5_digest_stream.sv
tb/md5_digest_checker.sv
tb/testbench.sv
